### src/adaptive_rice_swap_coeff_decoder_macros.svh
// Assertion macros shared by the decoder RTL.
`ifndef ADAPTIVE_RICE_SWAP_COEFF_DECODER_MACROS_SVH
`define ADAPTIVE_RICE_SWAP_COEFF_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ARSCD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("decoder check failed");

// Next-cycle implication, checked outside reset.
`define ARSCD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("decoder check failed");

`endif

### src/arscd_pkg.sv
// Types, constants and helper functions of the adaptive Rice coefficient decoder.
package arscd_pkg;

    typedef enum logic [1:0] {
        CMD_DEC_DC = 2'd0,
        CMD_DEC_AC = 2'd1,
        CMD_REINIT = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWAP,
        ST_WB,
        ST_INIT
    } state_t;

    localparam logic [7:0] RUN_MASK   = 8'h54;
    localparam logic [7:0] SIZE_MASK  = 8'hAB;
    localparam logic [2:0] K_MAX      = 3'd7;
    localparam logic [2:0] K_INIT     = 3'd4;
    localparam logic [4:0] ESC_USED   = 5'd16;
    localparam logic [3:0] ESC_ONES   = 4'd8;
    localparam int         SWAP_MUL   = 15;
    localparam int         SWAP_SHIFT = 4;
    localparam logic [7:0] TAB_LAST   = 8'hFF;

    // Rice index decode of one window
    typedef struct packed {
        logic [7:0] idx;
        logic [7:0] i1;
        logic [4:0] used;
        logic       err;
        logic [2:0] k_next;
    } rice_t;

    // Fields derived from one symbol
    typedef struct packed {
        logic [15:0] coeff;
        logic [2:0]  run;
        logic        eob;
        logic [4:0]  used;
    } sym_t;

    // One table write
    typedef struct packed {
        logic       we;
        logic [7:0] addr;
        logic [7:0] data;
    } tab_wr_t;

    // Reset content of the AC table: run bits sit at RUN_MASK, size bits at SIZE_MASK.
    function automatic logic [7:0] ac_init_value(input logic [7:0] addr);
        logic [2:0] run;
        logic [4:0] size;
        int         rn;
        int         sn;
        run  = '0;
        size = '0;
        rn   = 0;
        sn   = 0;
        for (int p = 0; p < 8; p++) begin
            if (RUN_MASK[p]) begin
                run[rn] = addr[p];
                rn++;
            end
            if (SIZE_MASK[p]) begin
                size[sn] = addr[p];
                sn++;
            end
        end
        return {run, size};
    endfunction

endpackage

### src/adaptive_rice_swap_coeff_decoder.sv
// Adaptive Rice swap-table coefficient decoder, top level.
//
// One beat in, one beat out. In a decode beat the accept cycle decodes the
// Rice index and reads the table at the index and at its swap partner, the
// swap step writes the partner value to the index and loads the result, the
// write-back step writes the old value to the partner; a decode error skips
// both writes. The single write port of each table splits the writes. A
// reinitialize beat, and reset, start a sweep that rewrites both tables one
// entry per cycle; no beat is accepted during it, and the reinitialize
// result (all zeros) comes out once the sweep ends. A no-op command (3)
// passes through with an all-zero result. A new beat is taken while the
// previous result waits on m_tready; the block only stalls in the swap
// step, before the result is loaded, while the output register is full.
`include "adaptive_rice_swap_coeff_decoder_macros.svh"

module adaptive_rice_swap_coeff_decoder
    import arscd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // input beats
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] bit_window
    input  logic [1:0]  s_tuser,   // [1:0] command
    // result beats
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [15:0] coeff_value, [18:16] zero_run, [23:19] bits_used
    output logic        m_tlast,   // end_marker
    output logic        m_tuser    // decode_error
);

    state_t      state_reg, state_next;
    cmd_t        op_reg;
    cmd_t        in_cmd;
    logic [31:0] win_reg;
    rice_t       rice_reg;
    logic        emit_reg;
    logic [7:0]  sweep_reg;
    logic [2:0]  dc_k_reg;
    logic [2:0]  ac_k_reg;

    logic        m_tvalid_reg;
    logic [23:0] m_tdata_reg;
    logic        m_tlast_reg;
    logic        m_tuser_reg;

    logic        accept;
    logic        slot_free;
    logic        load_out;
    logic        is_decode;
    logic        do_write;
    logic [2:0]  k_sel;
    rice_t       rice;
    sym_t        fields;
    logic [7:0]  sym_a;
    logic [7:0]  sym_b;
    tab_wr_t     dc_wr;
    tab_wr_t     ac_wr;
    logic [7:0]  dc_rd_a, dc_rd_b, ac_rd_a, ac_rd_b;
    logic [15:0] out_coeff;
    logic [2:0]  out_run;
    logic        out_eob;
    logic [4:0]  out_used;
    logic        out_err;

    assign in_cmd = cmd_t'(s_tuser);
    assign accept = s_tvalid && s_tready;
    assign k_sel  = (in_cmd == CMD_DEC_DC) ? dc_k_reg : ac_k_reg;

    arscd_rice_front u_front (
        .window (s_tdata),
        .k      (k_sel),
        .rice   (rice)
    );

    // both tables read at the same addresses; the context picks one later
    arscd_table_ram u_dc_tab (
        .aclk    (aclk),
        .wr      (dc_wr),
        .re      (accept),
        .raddr_a (rice.idx),
        .raddr_b (rice.i1),
        .rdata_a (dc_rd_a),
        .rdata_b (dc_rd_b)
    );

    arscd_table_ram u_ac_tab (
        .aclk    (aclk),
        .wr      (ac_wr),
        .re      (accept),
        .raddr_a (rice.idx),
        .raddr_b (rice.i1),
        .rdata_a (ac_rd_a),
        .rdata_b (ac_rd_b)
    );

    // sym_a: old entry at the index (the symbol), sym_b: old entry at the partner
    assign sym_a = (op_reg == CMD_DEC_DC) ? dc_rd_a : ac_rd_a;
    assign sym_b = (op_reg == CMD_DEC_DC) ? dc_rd_b : ac_rd_b;

    arscd_symbol_back u_back (
        .sym    (sym_a),
        .window (win_reg),
        .used   (rice_reg.used),
        .fields (fields)
    );

    assign is_decode = (op_reg == CMD_DEC_DC) || (op_reg == CMD_DEC_AC);
    assign do_write  = is_decode && !rice_reg.err;
    assign slot_free = !m_tvalid_reg || m_tready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = (in_cmd == CMD_REINIT) ? ST_INIT : ST_SWAP;
                end
            end
            ST_SWAP: begin
                if (slot_free) begin
                    state_next = do_write ? ST_WB : ST_IDLE;
                end
            end
            ST_WB: begin
                state_next = ST_IDLE;
            end
            ST_INIT: begin
                if (sweep_reg == TAB_LAST) begin
                    state_next = emit_reg ? ST_SWAP : ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // state outputs: handshake and table writes
    always_comb begin
        s_tready = 1'b0;
        load_out = 1'b0;
        dc_wr    = '0;
        ac_wr    = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
            end
            ST_SWAP: begin
                load_out = slot_free;
                if (slot_free && do_write) begin
                    dc_wr = '{we: (op_reg == CMD_DEC_DC), addr: rice_reg.idx, data: sym_b};
                    ac_wr = '{we: (op_reg == CMD_DEC_AC), addr: rice_reg.idx, data: sym_b};
                end
            end
            ST_WB: begin
                dc_wr = '{we: (op_reg == CMD_DEC_DC), addr: rice_reg.i1, data: sym_a};
                ac_wr = '{we: (op_reg == CMD_DEC_AC), addr: rice_reg.i1, data: sym_a};
            end
            ST_INIT: begin
                dc_wr = '{we: 1'b1, addr: sweep_reg, data: sweep_reg};
                ac_wr = '{we: 1'b1, addr: sweep_reg, data: ac_init_value(sweep_reg)};
            end
            default: ;
        endcase
    end

    // result fields
    always_comb begin
        out_coeff = '0;
        out_run   = '0;
        out_eob   = 1'b0;
        out_used  = '0;
        out_err   = 1'b0;
        if (is_decode) begin
            if (rice_reg.err) begin
                out_used = rice_reg.used;
                out_err  = 1'b1;
            end else begin
                out_coeff = fields.coeff;
                out_run   = fields.run;
                out_eob   = fields.eob;
                out_used  = fields.used;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_INIT;
            emit_reg  <= 1'b0;
            sweep_reg <= '0;
            dc_k_reg  <= K_INIT;
            ac_k_reg  <= K_INIT;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT) begin
                sweep_reg <= sweep_reg + 8'd1;
                if (sweep_reg == TAB_LAST) begin
                    emit_reg <= 1'b0;
                end
            end
            if (accept) begin
                unique case (in_cmd)
                    CMD_DEC_DC: dc_k_reg <= rice.k_next;
                    CMD_DEC_AC: ac_k_reg <= rice.k_next;
                    CMD_REINIT: begin
                        dc_k_reg <= K_INIT;
                        ac_k_reg <= K_INIT;
                        emit_reg <= 1'b1;
                    end
                    CMD_NOP: ;
                endcase
            end
        end
    end

    // item payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            op_reg   <= in_cmd;
            win_reg  <= s_tdata;
            rice_reg <= rice;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (load_out) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            m_tdata_reg <= {out_used, out_run, out_coeff};
            m_tlast_reg <= out_eob;
            m_tuser_reg <= out_err;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    `ARSCD_ASSERT_NOW(a_no_accept_busy, aclk, aresetn, (state_reg != ST_IDLE), !s_tready)
    `ARSCD_ASSERT_NOW(a_no_write_idle, aclk, aresetn, (dc_wr.we || ac_wr.we), (state_reg != ST_IDLE))
    `ARSCD_ASSERT_NOW(a_one_ctx_write, aclk, aresetn, (state_reg != ST_INIT), !(dc_wr.we && ac_wr.we))
    `ARSCD_ASSERT_NEXT(a_swap_to_wb, aclk, aresetn, (load_out && do_write), (state_reg == ST_WB))
    `ARSCD_ASSERT_NOW(a_err_clean, aclk, aresetn, (m_tvalid && m_tuser), ((m_tdata[18:0] == 19'd0) && !m_tlast))

endmodule

### src/arscd_table_ram.sv
// 256 x 8 symbol table memory: one write port, two registered read ports.
module arscd_table_ram
    import arscd_pkg::*;
(
    input  logic       aclk,
    input  tab_wr_t    wr,
    input  logic       re,
    input  logic [7:0] raddr_a,
    input  logic [7:0] raddr_b,
    output logic [7:0] rdata_a,
    output logic [7:0] rdata_b
);

    logic [7:0] mem [256];
    logic [7:0] rdata_a_reg;
    logic [7:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (wr.we) begin
            mem[wr.addr] <= wr.data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a_reg <= mem[raddr_a];
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

### src/arscd_rice_front.sv
// Adaptive Rice index decode, escape handling, k update and swap partner.
module arscd_rice_front
    import arscd_pkg::*;
(
    input  logic [31:0] window,
    input  logic [2:0]  k,
    output rice_t       rice
);

    logic [3:0]  q;
    logic        esc;
    logic [6:0]  rbits;
    logic [6:0]  kmask;
    logic [9:0]  idx_full;
    logic [11:0] prod;

    // run of ones at the low end, capped at eight
    always_comb begin
        q = ESC_ONES;
        for (int i = 7; i >= 0; i--) begin
            if (!window[i]) begin
                q = 4'(i);
            end
        end
    end

    assign esc   = (q == ESC_ONES);
    assign rbits = 7'(window[15:1] >> q[2:0]);
    assign kmask = 7'((8'd1 << k) - 8'd1);

    always_comb begin
        rice.k_next = k;
        if (esc) begin
            idx_full  = {2'b00, window[15:8]};
            rice.used = ESC_USED;
            if (k < K_MAX) begin
                rice.k_next = k + 3'd1;
            end
        end else begin
            idx_full  = (10'(q[2:0]) << k) | 10'(rbits & kmask);
            rice.used = 5'(q) + 5'(k) + 5'd1;
            if (q == 4'd0) begin
                if (k != 3'd0) begin
                    rice.k_next = k - 3'd1;
                end
            end else if (q > 4'd1) begin
                if (k < K_MAX) begin
                    rice.k_next = k + 3'd1;
                end
            end
        end
        prod     = 12'(idx_full[7:0]) * 12'(SWAP_MUL);
        rice.err = |idx_full[9:8];
        rice.idx = idx_full[7:0];
        rice.i1  = prod[SWAP_SHIFT +: 8];
    end

endmodule

### src/arscd_symbol_back.sv
// Symbol to zero run, end marker and zigzag coefficient with extra bits.
module arscd_symbol_back
    import arscd_pkg::*;
(
    input  logic [7:0]  sym,
    input  logic [31:0] window,
    input  logic [4:0]  used,
    output sym_t        fields
);

    logic [4:0]  b5;
    logic        small_cls;
    logic [3:0]  h;
    logic [31:0] shifted;
    logic [15:0] xmask;
    logic [15:0] v;

    assign b5        = sym[4:0];
    assign small_cls = (b5[4:2] == 3'd0);
    assign h         = 4'(b5[4:1]) - 4'd1;
    assign shifted   = window >> used;
    assign xmask     = (16'd1 << h) - 16'd1;

    always_comb begin
        if (small_cls) begin
            v = 16'(b5);
        end else begin
            v = (16'({1'b1, b5[0]}) << h) | (shifted[15:0] & xmask);
        end
    end

    always_comb begin
        if (sym == 8'd0) begin
            fields.coeff = '0;
            fields.run   = '0;
            fields.eob   = 1'b1;
            fields.used  = used;
        end else begin
            fields.coeff = {1'b0, v[15:1]} ^ {16{v[0]}};
            fields.run   = sym[7:5];
            fields.eob   = 1'b0;
            fields.used  = small_cls ? used : used + 5'(h);
        end
    end

endmodule

### tb/sv/tb.sv
// Self-checking bench for the adaptive Rice swap-table coefficient decoder.
module tb;
    import arscd_pkg::*;

    // expected fields of one result beat
    typedef struct packed {
        logic [15:0] coeff;
        logic [2:0]  run;
        logic        eob;
        logic [4:0]  used;
        logic        err;
    } coeff_result_t;

    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_LIMIT = 20000;
    localparam int RUN_LIMIT   = 1000000;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        m_tlast;
    logic        m_tuser;

    // shadow of the symbol tables and Rice parameters, index 0 DC, 1 AC
    logic [7:0]    sym_tab [2][256];
    logic [2:0]    rice_k [2];
    coeff_result_t expected_q [$];

    int mismatches;
    int beats_seen;
    bit no_idle;
    bit hold_req;

    adaptive_rice_swap_coeff_decoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #2 aclk = ~aclk;
    end

    initial begin
        #(4 * RUN_LIMIT);
        $display("adaptive_rice_swap_coeff_decoder test failed");
        $finish;
    end

    // DC table identity; AC table holds (run<<5)|size at the run/size bits spread over the masks
    function automatic void init_tables();
        logic [7:0] addr;
        logic [2:0] r3;
        logic [4:0] s5;
        int         rn;
        int         sn;
        for (int i = 0; i < 256; i++) begin
            sym_tab[0][i] = i[7:0];
        end
        for (int r = 0; r < 8; r++) begin
            for (int s = 0; s < 32; s++) begin
                r3   = r[2:0];
                s5   = s[4:0];
                addr = '0;
                rn   = 0;
                sn   = 0;
                for (int p = 0; p < 8; p++) begin
                    if (RUN_MASK[p]) begin
                        addr[p] = r3[rn];
                        rn++;
                    end
                    if (SIZE_MASK[p]) begin
                        addr[p] = s5[sn];
                        sn++;
                    end
                end
                sym_tab[1][addr] = {r3, s5};
            end
        end
        rice_k[0] = K_INIT;
        rice_k[1] = K_INIT;
    endfunction

    // Decode one beat against the shadow state and update it
    function automatic coeff_result_t decode_symbol(input logic [1:0] cmd,
                                                    input logic [31:0] win);
        coeff_result_t res;
        int            ctx;
        int            k;
        int            q;
        int            idx;
        int            used;
        int            i1;
        int            b5;
        int            h;
        logic [7:0]    sym;
        logic [31:0]   v;
        logic [31:0]   extra;
        logic [31:0]   zz;
        res = '0;
        if (cmd == CMD_REINIT) begin
            init_tables();
            return res;
        end
        if (cmd == CMD_NOP) begin
            return res;
        end
        ctx = (cmd == CMD_DEC_AC) ? 1 : 0;
        k   = int'(rice_k[ctx]);
        q   = 0;
        while (q < 8 && win[q]) q++;
        if (q == 8) begin
            // escape: raw index byte follows eight ones
            idx  = int'(win[15:8]);
            used = 16;
            if (k < K_MAX) k++;
        end else begin
            idx  = (q << k) | ((win >> (q + 1)) & ((1 << k) - 1));
            used = q + k + 1;
            if (q == 0) begin
                if (k > 0) k--;
            end else if (q > 1 && k < K_MAX) begin
                k++;
            end
        end
        rice_k[ctx] = k[2:0];
        res.used    = used[4:0];
        if (idx > 255) begin
            res.err = 1'b1;
            return res;
        end
        i1 = (idx * 15) >> 4;
        sym = sym_tab[ctx][idx];
        sym_tab[ctx][idx] = sym_tab[ctx][i1];
        sym_tab[ctx][i1]  = sym;
        if (sym == 8'd0) begin
            res.eob = 1'b1;
            return res;
        end
        b5 = int'(sym[4:0]);
        if (b5 < 4) begin
            v = b5;
        end else begin
            h     = (b5 >> 1) - 1;
            extra = (win >> used) & ((32'd1 << h) - 32'd1);
            v     = (((b5 | 2) & 3) << h) | extra;
            used  = used + h;
        end
        zz        = (v >> 1) ^ (32'd0 - (v & 32'd1));
        res.coeff = zz[15:0];
        res.run   = sym[7:5];
        res.used  = used[4:0];
        return res;
    endfunction

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99, 0);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(3, 1);
        return $urandom_range(40, 10);
    endfunction

    // well-formed Rice codes with random payload, some escapes and some raw noise
    function automatic logic [31:0] random_window();
        logic [31:0] w;
        int          sel;
        int          q;
        w   = $urandom;
        sel = $urandom_range(99, 0);
        if (sel < 10) return w;
        if (sel < 25) begin
            w[7:0] = 8'hFF;
            return w;
        end
        sel = $urandom_range(9, 0);
        if (sel < 3) q = 0;
        else if (sel < 6) q = 1;
        else q = $urandom_range(7, 2);
        for (int j = 0; j < q; j++) w[j] = 1'b1;
        w[q] = 1'b0;
        return w;
    endfunction

    function automatic cmd_t random_cmd();
        int r;
        r = $urandom_range(99, 0);
        if (r < 2) return CMD_REINIT;
        if (r < 5) return CMD_NOP;
        if (r < 52) return CMD_DEC_DC;
        return CMD_DEC_AC;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("mismatch at result beat %0d, %s: got %0h, expected %0h",
                 beats_seen, what, got, want);
    endtask

    // Offer one beat from a falling edge, hold it until accepted, then predict
    task automatic send_item(input cmd_t cmd, input logic [31:0] win);
        int gap;
        gap = no_idle ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = win;
        s_tuser  = cmd;
        do @(posedge aclk); while (!s_tready);
        expected_q.push_back(decode_symbol(cmd, win));
    endtask

    // Receiver: random stalls, plus one long hold-off on request
    initial begin
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_req = 1'b0;
            end else if (stall_left > 0) begin
                m_tready = 1'b0;
                stall_left--;
            end else begin
                m_tready = 1'b1;
                if (!no_idle && $urandom_range(3, 0) == 0) stall_left = pick_gap();
            end
        end
    end

    // Result checker
    always @(posedge aclk) begin : check_results
        coeff_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("beat with nothing expected",
                                32'({m_tuser, m_tlast, m_tdata}), 32'd0);
            end else begin
                want = expected_q.pop_front();
                if (m_tdata[15:0] !== want.coeff)
                    report_mismatch("coeff_value", 32'(m_tdata[15:0]), 32'(want.coeff));
                if (m_tdata[18:16] !== want.run)
                    report_mismatch("zero_run", 32'(m_tdata[18:16]), 32'(want.run));
                if (m_tdata[23:19] !== want.used)
                    report_mismatch("bits_used", 32'(m_tdata[23:19]), 32'(want.used));
                if (m_tlast !== want.eob)
                    report_mismatch("end_marker", 32'(m_tlast), 32'(want.eob));
                if (m_tuser !== want.err)
                    report_mismatch("decode_error", 32'(m_tuser), 32'(want.err));
            end
            beats_seen++;
        end
    end

    // Extremes, escapes, saturation of k, error path, largest size classes, commands
    task automatic test_directed();
        send_item(CMD_REINIT, 32'h0000_0000);
        send_item(CMD_DEC_DC, 32'h0000_0000);   // q=0, index 0: end marker
        send_item(CMD_DEC_DC, 32'hFFFF_FFFF);   // escape to index 255
        send_item(CMD_DEC_DC, 32'h0000_00FF);   // escape to index 0
        send_item(CMD_DEC_DC, 32'h1234_80FF);   // escape, k reaches 6
        send_item(CMD_DEC_DC, 32'h5555_7FFF);   // escape, k reaches 7
        send_item(CMD_DEC_DC, 32'hFFFF_FFFB);   // q=2 at k=7: index above 255, k saturates
        send_item(CMD_DEC_DC, 32'h0000_007F);   // q=7: index above 255
        send_item(CMD_DEC_DC, 32'hAAAA_AAAA);   // q=0: k steps down
        send_item(CMD_DEC_DC, 32'h5555_5554);
        send_item(CMD_DEC_DC, 32'h0F0F_0F01);   // q=1: k unchanged
        send_item(CMD_DEC_AC, 32'hFFFF_ABFF);   // size 31, all extra bits set
        send_item(CMD_REINIT, 32'hFFFF_FFFF);
        send_item(CMD_DEC_AC, 32'h0000_FFFF);   // run 7, size 31, extra bits clear
        send_item(CMD_DEC_AC, 32'h0001_08FF);   // size class 4, one extra bit
        send_item(CMD_DEC_AC, 32'h0000_01FF);   // small size class
        send_item(CMD_DEC_AC, 32'h0000_0000);
        send_item(CMD_DEC_AC, 32'h8000_0006);
        send_item(CMD_NOP,    32'hFFFF_FFFF);
        send_item(CMD_NOP,    32'h0000_0000);
        send_item(CMD_DEC_DC, 32'h0000_0001);
        send_item(CMD_REINIT, 32'h0000_0000);
    endtask

    task automatic test_random(input int n);
        for (int i = 0; i < n; i++) send_item(random_cmd(), random_window());
    endtask

    // Full rate on both sides
    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        for (int i = 0; i < n; i++) send_item(random_cmd(), random_window());
        no_idle = 1'b0;
    endtask

    // Receiver stops for a long stretch while beats keep coming
    task automatic test_backpressure(input int n);
        @(posedge aclk);
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int i = 0; i < n; i++) begin
            send_item((i % 2 == 0) ? CMD_DEC_DC : CMD_DEC_AC, random_window());
        end
        no_idle = 1'b0;
    endtask

    initial begin
        int waited;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        mismatches = 0;
        beats_seen = 0;
        init_tables();
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_directed();
        test_random(400);
        test_backpressure(40);
        test_back_to_back(120);
        test_random(420);

        @(negedge aclk);
        s_tvalid = 1'b0;
        waited   = 0;
        while (expected_q.size() > 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        if (expected_q.size() > 0)
            report_mismatch("results never arrived", 32'(expected_q.size()), 32'd0);
        repeat (20) @(posedge aclk);

        if (mismatches == 0) begin
            $display("adaptive_rice_swap_coeff_decoder test passed");
        end else begin
            $display("adaptive_rice_swap_coeff_decoder test failed");
        end
        $finish;
    end

endmodule
